// ===== rtl/core/dtkg_pkg.sv =====
// shared types, constants and table builders for the dual tone keypad generator
package dtkg_pkg;

  // phase accumulator and cosine table geometry
  localparam int unsigned PHASE_BITS         = 24;
  localparam int unsigned COSINE_TABLE_DEPTH = 1024;
  localparam int unsigned COS_ADDR_W         = $clog2(COSINE_TABLE_DEPTH);
  localparam int unsigned COS_W              = 16;
  localparam int unsigned NUM_TONES          = 20;
  localparam int unsigned TONE_W             = 5;

  // sample rate in millihertz and fixed point constants
  localparam longint unsigned RATE_MHZ = 64'd11025000;
  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam longint          ONE_Q30  = 64'sd1073741824;

  // taylor term divisors, (2n+1)(2n+2) for cosine and (2n+2)(2n+3) for sine
  localparam longint unsigned COS_TERM_DIV [8] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
  };
  localparam longint unsigned SIN_TERM_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // configuration register indexes
  localparam logic REG_TONE_SAMPLES = 1'b0;
  localparam logic REG_RAMP_STEP    = 1'b1;

  // key codes
  localparam logic [7:0] KEY_STAR = 8'h6a;
  localparam logic [7:0] KEY_HASH = 8'hde;
  localparam logic [7:0] KEY_X    = 8'h58;
  localparam logic [7:0] KEY_Y    = 8'h59;
  localparam logic [7:0] KEY_Z    = 8'h5a;
  localparam logic [7:0] KEY_E    = 8'h45;

  // input and output beats
  typedef struct packed {
    logic       cmd;
    logic [7:0] key_code;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       last_sample;
  } out_beat_t;

  typedef struct packed {
    logic              ok;
    logic [TONE_W-1:0] idx;
  } key_map_t;

  typedef logic signed [COS_W-1:0] cos_lut_t [COSINE_TABLE_DEPTH];
  typedef logic [PHASE_BITS-1:0]   inc_lut_t [NUM_TONES];

  // phase increment: round(f * 2^PHASE_BITS / rate)
  function automatic logic [PHASE_BITS-1:0] phase_inc(longint unsigned mhz);
    longint unsigned num;
    num = (mhz << PHASE_BITS) + (RATE_MHZ / 2);
    return PHASE_BITS'(num / RATE_MHZ);
  endfunction

  // one cosine entry from the quadrant and taylor series routine
  function automatic logic signed [COS_W-1:0] cos_entry(int unsigned k);
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned tc;
    longint unsigned ts;
    longint          c;
    longint          s;
    longint          v;
    longint          res;
    int unsigned     quad;
    a    = 64'(4 * (k % COSINE_TABLE_DEPTH));
    quad = 32'(a / COSINE_TABLE_DEPTH);
    x    = ((a % COSINE_TABLE_DEPTH) * PI_Q30) / (2 * COSINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    tc   = 64'd1073741824;
    ts   = x;
    c    = 0;
    s    = 0;
    for (int n = 0; n < 8; n++) begin
      if ((n % 2) == 1) begin
        c = c - longint'(tc);
        s = s - longint'(ts);
      end else begin
        c = c + longint'(tc);
        s = s + longint'(ts);
      end
      tc = ((tc * x2) >> 30) / COS_TERM_DIV[n];
      ts = ((ts * x2) >> 30) / SIN_TERM_DIV[n];
    end
    case (quad)
      0:       v = c;
      1:       v = -s;
      2:       v = -c;
      default: v = s;
    endcase
    if (v > ONE_Q30) v = ONE_Q30;
    if (v < -ONE_Q30) v = -ONE_Q30;
    res = ((v + ONE_Q30 + 64'sd32768) >>> 16) - 64'sd16384;
    return COS_W'(res);
  endfunction

  function automatic cos_lut_t build_cos_lut();
    cos_lut_t lut;
    for (int i = 0; i < COSINE_TABLE_DEPTH; i++) begin
      lut[i] = cos_entry(i);
    end
    return lut;
  endfunction

  // low and high group increments per tone
  localparam inc_lut_t LO_INC = '{
    phase_inc(941000), phase_inc(697000), phase_inc(697000), phase_inc(697000),
    phase_inc(770000), phase_inc(770000), phase_inc(770000), phase_inc(852000),
    phase_inc(852000), phase_inc(852000), phase_inc(697000), phase_inc(770000),
    phase_inc(852000), phase_inc(941000), phase_inc(941000), phase_inc(941000),
    phase_inc(20000),  phase_inc(100000), phase_inc(500000), phase_inc(329628)
  };

  localparam inc_lut_t HI_INC = '{
    phase_inc(1336000), phase_inc(1209000), phase_inc(1336000), phase_inc(1477000),
    phase_inc(1209000), phase_inc(1336000), phase_inc(1477000), phase_inc(1209000),
    phase_inc(1336000), phase_inc(1477000), phase_inc(1633000), phase_inc(1633000),
    phase_inc(1633000), phase_inc(1633000), phase_inc(1209000), phase_inc(1477000),
    phase_inc(20000),   phase_inc(100000),  phase_inc(500000),  phase_inc(329628)
  };

  // key code to tone index
  function automatic key_map_t key_to_tone(logic [7:0] key);
    key_map_t m;
    m.ok  = 1'b1;
    m.idx = '0;
    if (key >= 8'h30 && key <= 8'h39) begin
      m.idx = TONE_W'(key - 8'h30);
    end else if (key >= 8'h41 && key <= 8'h44) begin
      m.idx = TONE_W'(key - 8'h41 + 8'd10);
    end else begin
      case (key)
        KEY_STAR: m.idx = TONE_W'(14);
        KEY_HASH: m.idx = TONE_W'(15);
        KEY_X:    m.idx = TONE_W'(16);
        KEY_Y:    m.idx = TONE_W'(17);
        KEY_Z:    m.idx = TONE_W'(18);
        KEY_E:    m.idx = TONE_W'(19);
        default:  m.ok  = 1'b0;
      endcase
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/dual_tone_keypad_generator.sv =====
// dual tone keypad generator: key decode, phase state and sample sequencer
// key press beat: taken in idle, no output beat.
// sample tick beat: lo, hi, r, g, p, v, out states to the output register, one multiplier
// reused five times, one cosine rom port read twice; input stalls until the out slot frees.
// a waiting output beat does not block input; a finished sample waits for the output slot.
// reset (rst_ni low, async): idle, tone off, phases and count zero, registers to defaults.
module dual_tone_keypad_generator import dtkg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_beat_t  out_data_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LO   = 8'b0000_0010,
    ST_HI   = 8'b0000_0100,
    ST_R    = 8'b0000_1000,
    ST_G    = 8'b0001_0000,
    ST_P    = 8'b0010_0000,
    ST_V    = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [10:0]           tone_samples_q;
  logic [15:0]           ramp_step_q;
  logic [PHASE_BITS-1:0] lo_phase_q;
  logic [PHASE_BITS-1:0] hi_phase_q;
  logic [TONE_W-1:0]     tone_idx_q;
  logic [10:0]           cnt_q;
  logic                  active_q;
  logic                  out_valid_q;
  out_beat_t             out_data_q;

  logic signed [16:0] sum_q;
  logic [16:0]        a_q;
  logic [16:0]        r_q;

  logic                   in_acc;
  logic                   out_free;
  key_map_t               km;
  logic [COS_ADDR_W-1:0]  rom_addr;
  logic signed [COS_W-1:0] rom_data;
  logic                   mul_en;
  logic signed [33:0]     op_a;
  logic signed [17:0]     op_b;
  logic signed [47:0]     prod;
  logic [10:0]            n_eff;
  logic [11:0]            rem;
  logic [10:0]            rem_cl;
  logic [32:0]            g_sum;
  logic [16:0]            g;
  logic [16:0]            clip;
  logic [47:0]            num;
  logic                   last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign km          = key_to_tone(in_data_i.key_code);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // burst length, zero treated as one
  assign n_eff  = (tone_samples_q == '0) ? 11'd1 : tone_samples_q;
  assign rem    = {1'b0, n_eff} - {1'b0, cnt_q};
  assign rem_cl = (cnt_q < n_eff) ? rem[10:0] : '0;
  assign last   = ({1'b0, cnt_q} + 12'd1) >= {1'b0, n_eff};

  // gain clip to one and rounded gain product
  assign clip  = (prod > 48'sd65536) ? 17'd65536 : prod[16:0];
  assign g_sum = prod[32:0] + 33'd32768;
  assign g     = g_sum[32:16];

  // bias and take top byte
  assign num = $unsigned(prod) + 48'h4000_4000_0000;

  // rom address, low phase first then high
  assign rom_addr = (state_q == ST_LO) ? lo_phase_q[PHASE_BITS-1 -: COS_ADDR_W]
                                       : hi_phase_q[PHASE_BITS-1 -: COS_ADDR_W];

  dtkg_cos_rom u_rom (
    .clk_i   (clk_i),
    .addr_i  (rom_addr),
    .rdata_o (rom_data)
  );

  // multiplier operand select per step
  always_comb begin
    mul_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    unique case (state_q)
      ST_LO: begin
        mul_en = 1'b1;
        op_a   = $signed({23'b0, cnt_q});
        op_b   = $signed({2'b0, ramp_step_q});
      end
      ST_HI: begin
        mul_en = 1'b1;
        op_a   = $signed({23'b0, rem_cl});
        op_b   = $signed({2'b0, ramp_step_q});
      end
      ST_G: begin
        mul_en = 1'b1;
        op_a   = $signed({17'b0, a_q});
        op_b   = $signed({1'b0, r_q});
      end
      ST_P: begin
        mul_en = 1'b1;
        op_a   = 34'(sum_q);
        op_b   = $signed({1'b0, g});
      end
      ST_V: begin
        mul_en = 1'b1;
        op_a   = prod[33:0];
        op_b   = 18'sd32766;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  dtkg_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.cmd && active_q) state_d = ST_LO;
      end
      ST_LO:  state_d = ST_HI;
      ST_HI:  state_d = ST_R;
      ST_R:   state_d = ST_G;
      ST_G:   state_d = ST_P;
      ST_P:   state_d = ST_V;
      ST_V:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and tone state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      tone_samples_q <= 11'd1102;
      ramp_step_q    <= 16'd2972;
      lo_phase_q     <= '0;
      hi_phase_q     <= '0;
      tone_idx_q     <= '0;
      cnt_q          <= '0;
      active_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TONE_SAMPLES) tone_samples_q <= cfg_wdata_i[10:0];
        if (cfg_idx_i == REG_RAMP_STEP) ramp_step_q <= cfg_wdata_i;
      end
      // key press restarts the burst
      if (in_acc && !in_data_i.cmd && km.ok) begin
        tone_idx_q <= km.idx;
        lo_phase_q <= '0;
        hi_phase_q <= '0;
        cnt_q      <= '0;
        active_q   <= 1'b1;
      end
      // output slot
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      // finished sample: deliver and advance
      if (state_q == ST_OUT && out_free) begin
        lo_phase_q  <= lo_phase_q + LO_INC[tone_idx_q];
        hi_phase_q  <= hi_phase_q + HI_INC[tone_idx_q];
        cnt_q       <= cnt_q + 11'd1;
        if (last) active_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_HI: begin
        sum_q <= 17'(rom_data);
        a_q   <= clip;
      end
      ST_R: begin
        sum_q <= sum_q + 17'(rom_data);
        r_q   <= clip;
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_q.sample      <= num[46:39];
          out_data_q.last_sample <= last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/dtkg_cos_rom.sv =====
// cosine table rom, q1.14 entries, registered read
module dtkg_cos_rom import dtkg_pkg::*; (
  input  logic                    clk_i,
  input  logic [COS_ADDR_W-1:0]   addr_i,
  output logic signed [COS_W-1:0] rdata_o
);

  localparam cos_lut_t CosLut = build_cos_lut();

  // one read per cycle
  always_ff @(posedge clk_i) begin
    rdata_o <= CosLut[addr_i];
  end

endmodule

// ===== rtl/core/dtkg_mul.sv =====
// shared signed multiplier with registered product
module dtkg_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] op_a_i,
  input  logic signed [17:0] op_b_i,
  output logic signed [47:0] prod_o
);

  logic signed [51:0] full;

  assign full = op_a_i * op_b_i;

  // product register, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= full[47:0];
    end
  end

endmodule
